// ===== src/rrsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsi_pkg
// Shared types and constants of the round-robin stream interleaver.
// ----------------------------------------------------------------------------
package rrsi_pkg;

  // Default sizes of the block
  localparam int NUM_STREAMS_DEF  = 4;
  localparam int STREAM_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 32;

  // Fixed payload field widths
  localparam int STREAM_ID_W = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;

  // Request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

endpackage

// ===== src/rrsi_if.sv =====
// ----------------------------------------------------------------------------
// rrsi_if
// Valid/ready channels of the interleaver: request in, result out.
// ----------------------------------------------------------------------------
interface rrsi_req_if;
  import rrsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [STREAM_ID_W-1:0]    stream_id;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, req_type, stream_id, value, input ready);
  modport sink   (input valid, req_type, stream_id, value, output ready);
endinterface

interface rrsi_rsp_if;
  import rrsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [STREAM_ID_W-1:0]    served_stream;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, out_value, served_stream, status, input ready);
  modport sink   (input valid, out_value, served_stream, status, output ready);
endinterface

// ===== src/rrsi_ram.sv =====
// ----------------------------------------------------------------------------
// rrsi_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rrsi_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/round_robin_stream_interleaver.sv =====
// ----------------------------------------------------------------------------
// round_robin_stream_interleaver
// Several FIFO streams of signed words in one shared RAM. A push appends to
// one stream (dropped when full or out of range); a pull returns the oldest
// word of the next non-empty stream in cyclic order after the one served last.
//
//   channel | dir | payload                               | handshake
//   --------+-----+---------------------------------------+------------
//   req     | in  | req_type, stream_id, value            | valid/ready
//   rsp     | out | out_value, served_stream, status      | valid/ready
//
// A push or an empty pull loads the output register directly; a successful
// pull first reads the stream RAM, whose read data is registered, and then
// loads the output register. The result sits in that output register; the
// next request is taken in the cycle that register drains.
// Synchronous reset clears pointers, fill counts and the round-robin pointer;
// the RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_stream_interleaver #(
  parameter int NUM_STREAMS  = rrsi_pkg::NUM_STREAMS_DEF,
  parameter int STREAM_DEPTH = rrsi_pkg::STREAM_DEPTH_DEF,
  parameter int DATA_WIDTH   = rrsi_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rrsi_req_if.sink    req,
  rrsi_rsp_if.source  rsp
);
  import rrsi_pkg::*;

  localparam int SW        = $clog2(NUM_STREAMS);
  localparam int PW        = $clog2(STREAM_DEPTH);
  localparam int CW        = $clog2(STREAM_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_STREAMS * STREAM_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  // Per-stream control state
  logic [PW-1:0] read_pointer  [NUM_STREAMS];
  logic [PW-1:0] write_pointer [NUM_STREAMS];
  logic [CW-1:0] fill_count    [NUM_STREAMS];
  logic [SW-1:0] next_stream;

  // Pull waiting on RAM read data
  logic          pend;
  logic [SW-1:0] pend_stream;

  // Output register
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [STREAM_ID_W-1:0]    served_r;
  status_t                   status_r;

  logic                      in_fire;
  logic                      is_push;
  logic                      push_in_range;
  logic                      push_full;
  logic                      push_ok;
  logic [SW-1:0]             push_sid;
  logic signed [63:0]        push_ext;
  logic                      found;
  logic [SW-1:0]             sel;
  logic [SW-1:0]             sel_next;
  logic                      we;
  logic                      re;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic [DATA_WIDTH-1:0]     rdata;
  logic signed [63:0]        rd_ext;
  logic                      load_out;

  // Handshake: one request at a time, held off while a pull waits on the RAM or a stalled result is held
  assign req.ready = !pend && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;
  assign is_push   = (req.req_type == REQ_PUSH);

  // Push decode
  assign push_sid      = SW'(req.stream_id);
  assign push_in_range = int'(req.stream_id) < NUM_STREAMS;
  assign push_full     = (fill_count[push_sid] == CW'(STREAM_DEPTH));
  assign push_ok       = push_in_range && !push_full;
  assign push_ext      = 64'(req.value);

  // Rotating priority pick starting at next_stream
  always_comb begin
    int            idx;
    logic [SW-1:0] cand;
    found = 1'b0;
    sel   = '0;
    for (int k = NUM_STREAMS - 1; k >= 0; k--) begin
      idx = int'(next_stream) + k;
      if (idx >= NUM_STREAMS) begin
        idx = idx - NUM_STREAMS;
      end
      cand = SW'(idx);
      if (fill_count[cand] != '0) begin
        found = 1'b1;
        sel   = cand;
      end
    end
  end

  assign sel_next = (sel == SW'(NUM_STREAMS - 1)) ? '0 : sel + SW'(1);

  // Output register loads this cycle
  assign load_out = pend || (in_fire && (is_push || !found));

  // RAM access
  assign we    = in_fire && is_push && push_ok;
  assign waddr = AW'(int'(push_sid) * STREAM_DEPTH + int'(write_pointer[push_sid]));
  assign re    = in_fire && !is_push && found;
  assign raddr = AW'(int'(sel) * STREAM_DEPTH + int'(read_pointer[sel]));

  rrsi_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_ext[DATA_WIDTH-1:0]),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ext = 64'($signed(rdata));

  // Stream state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        read_pointer[i]  <= '0;
        write_pointer[i] <= '0;
        fill_count[i]    <= '0;
      end
      next_stream <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load_out) begin
        out_valid <= 1'b0;
      end

      // Read data of a pending pull lands in the output register
      if (pend) begin
        pend        <= 1'b0;
        out_valid   <= 1'b1;
        out_value_r <= rd_ext[VALUE_W-1:0];
        served_r    <= STREAM_ID_W'(pend_stream);
        status_r    <= ST_OK;
      end

      if (in_fire) begin
        if (is_push) begin
          out_valid   <= 1'b1;
          out_value_r <= '0;
          served_r    <= '0;
          status_r    <= push_ok ? ST_OK : ST_DROPPED;
          if (push_ok) begin
            write_pointer[push_sid] <=
              (write_pointer[push_sid] == PW'(STREAM_DEPTH - 1)) ? '0
                                                                : write_pointer[push_sid] + PW'(1);
            fill_count[push_sid] <= fill_count[push_sid] + CW'(1);
          end
        end else if (found) begin
          pend              <= 1'b1;
          pend_stream       <= sel;
          read_pointer[sel] <= (read_pointer[sel] == PW'(STREAM_DEPTH - 1)) ? '0
                                                                           : read_pointer[sel] + PW'(1);
          fill_count[sel]   <= fill_count[sel] - CW'(1);
          next_stream       <= sel_next;
        end else begin
          out_valid   <= 1'b1;
          out_value_r <= '0;
          served_r    <= '0;
          status_r    <= ST_EMPTY;
        end
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.out_value     = out_value_r;
  assign rsp.served_stream = served_r;
  assign rsp.status        = status_r;

  // A read issued for a pull turns into a pending pull next cycle
  a_read_pends: assert property (@(posedge clk) disable iff (rst) re |=> pend)
    else $error("RAM read issued without a pending pull");

  // A pending pull delivers an ok result in the following cycle
  a_pull_result: assert property (@(posedge clk) disable iff (rst)
    pend |=> (rsp.valid && rsp.status == ST_OK))
    else $error("pending pull did not deliver a result");

  // A push that cannot be stored reports a drop
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_push && !push_ok) |=> (rsp.valid && rsp.status == ST_DROPPED))
    else $error("dropped push not flagged");

  // An empty pull reports empty and leaves the round-robin pointer alone
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_push && !found) |=> (rsp.status == ST_EMPTY && $stable(next_stream)))
    else $error("empty pull handled wrongly");

  // No RAM write overlaps a pull waiting on read data
  a_interlock: assert property (@(posedge clk) disable iff (rst) pend |-> !we)
    else $error("RAM write during pending pull");

endmodule
